### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL files. Defining
// ASSERT_OFF turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/adpc_pkg.sv
// ----------------------------------------------------------------------------
// Actuator deadband position control package
// Shared constants, codes and types of the position control unit.
// ----------------------------------------------------------------------------
package adpc_pkg;

    // Averaging window depth and position scale factor.
    localparam int WINDOW = 10;
    localparam int SCALE  = 1;

    localparam int POS_W   = 16;
    localparam int SPEED_W = 8;
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int GOAL_W  = POS_W + SCALE_W;
    localparam int OFF_W   = POS_W + SCALE_W + 1;
    localparam int SAMP_W  = OFF_W + 1;

    // Division by WINDOW as a multiply by a rounded-up reciprocal. With the
    // shift at POS_W plus the bit count of WINDOW the quotient is exact for
    // every 16-bit sample.
    localparam int  DIV_SHIFT = POS_W + $clog2(WINDOW);
    localparam int  MULT_W    = 18;
    localparam int  PROD_W    = 40;
    localparam longint DIV_MULT = ((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd3;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd255;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    // Update request from the pipeline into the averaging ring.
    typedef struct packed {
        logic             push;
        logic [POS_W-1:0] quot;
    } avg_req_t;

endpackage

### hw/rtl/adpc_avg.sv
// ----------------------------------------------------------------------------
// Moving average ring
// Holds the last WINDOW sample quotients and a running sum of them. The
// next sum is offered combinationally so the caller can register it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adpc_avg
    import adpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  avg_req_t         req,
    output logic [POS_W-1:0] sum_next
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    logic [POS_W-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [POS_W-1:0] sum_reg;

    // The oldest quotient leaves the sum as the new one enters. Arithmetic
    // wraps at 16 bits, which matches the truncated sum.
    assign sum_next = sum_reg - ring_reg[idx_reg] + req.quot;
    assign idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (req.push)
        begin
            ring_reg[idx_reg] <= req.quot;
            idx_reg           <= idx_next;
            sum_reg           <= sum_next;
        end
    end

    `ASSERT_CLK(a_idx_range, clk, rst_n, idx_reg <= LAST_IDX, "ring index beyond window")
    `ASSERT_NEXT(a_sum_hold, clk, rst_n, !req.push, $stable(sum_reg), "sum moved without push")
    `ASSERT_NEXT(a_idx_step, clk, rst_n, req.push && idx_reg != LAST_IDX,
        idx_reg == IDX_W'($past(idx_reg) + 1'b1), "ring index did not advance")

endmodule

### hw/rtl/actuator_deadband_position_control_unit.sv
// ----------------------------------------------------------------------------
// Actuator deadband position control unit
// Offsets and clamps each range sample, averages it over a ring of WINDOW
// samples and drives the actuator toward the goal outside a deadband.
// ----------------------------------------------------------------------------
// Path: an accepted item passes through the input register and the quotient
// register before it is loaded into the result register, where it can be taken.
// Throughput: one item per cycle; the three-stage pipeline stalls as a
// whole only while a finished result waits on out_stall.
// The running sum and the ring index in the averaging ring feed back through their own registers.
// Reset clears the ring, its index and sum, and loads register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module actuator_deadband_position_control_unit
    import adpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    // Sample input channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [POS_W-1:0]     raw_sample,
    // Result output channel.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           direction,
    output logic [SPEED_W-1:0]   drive_level,
    output logic [POS_W-1:0]     filtered_position
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   target_reg;
    logic [POS_W-1:0]   tolerance_reg;
    logic [POS_W-1:0]   offset_reg;
    logic [SPEED_W-1:0] speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            tolerance_reg <= '0;
            offset_reg    <= '0;
            speed_reg     <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET:    target_reg    <= cfg_data;
                REG_TOLERANCE: tolerance_reg <= cfg_data;
                REG_OFFSET:    offset_reg    <= cfg_data;
                REG_SPEED:     speed_reg     <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. All stages move together unless a finished
    // result is being held back by the consumer. Empty stages move too,
    // so the input side keeps flowing while the output register is free.
    // ------------------------------------------------------------------
    logic advance;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // ------------------------------------------------------------------
    // Stage A: input register.
    // ------------------------------------------------------------------
    logic             a_valid_reg;
    logic [POS_W-1:0] a_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            a_raw_reg <= raw_sample;
        end
    end

    // Offset the sample, clamp it to the 16-bit range and divide it by the
    // window depth through the reciprocal multiply.
    logic signed [OFF_W-1:0]  off_scaled;
    logic signed [SAMP_W-1:0] sample_sum;
    logic [POS_W-1:0]         sample_clamped;
    logic [PROD_W-1:0]        quot_prod;
    logic [POS_W-1:0]         a_quot;

    assign off_scaled = OFF_W'($signed(offset_reg)) * $signed(OFF_W'(SCALE));
    assign sample_sum = $signed(SAMP_W'(a_raw_reg)) + SAMP_W'(off_scaled);

    always_comb
    begin
        if (sample_sum < 0)
        begin
            sample_clamped = '0;
        end
        else if (sample_sum > $signed(SAMP_W'({POS_W{1'b1}})))
        begin
            sample_clamped = '1;
        end
        else
        begin
            sample_clamped = sample_sum[POS_W-1:0];
        end
    end

    assign quot_prod = PROD_W'(sample_clamped) * PROD_W'(MULT_W'(DIV_MULT));
    assign a_quot    = quot_prod[DIV_SHIFT +: POS_W];

    // ------------------------------------------------------------------
    // Stage B: quotient register feeding the averaging ring.
    // ------------------------------------------------------------------
    logic             b_valid_reg;
    logic [POS_W-1:0] b_quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            b_quot_reg <= a_quot;
        end
    end

    avg_req_t         avg_req;
    logic [POS_W-1:0] avg_sum;

    assign avg_req.push = advance && b_valid_reg;
    assign avg_req.quot = b_quot_reg;

    adpc_avg u_avg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (avg_req),
        .sum_next (avg_sum)
    );

    // Deadband decision. Goal and band are kept at full scaled width so a
    // large scale never wraps. A difference equal to the band counts as
    // inside and stops the actuator.
    logic [GOAL_W-1:0] goal;
    logic [GOAL_W-1:0] band;
    logic [GOAL_W-1:0] pos_ext;
    dir_t              dir_next;
    logic [SPEED_W-1:0] level_next;

    assign goal    = GOAL_W'(target_reg) * GOAL_W'(SCALE);
    assign band    = GOAL_W'(tolerance_reg) * GOAL_W'(SCALE);
    assign pos_ext = GOAL_W'(avg_sum);

    always_comb
    begin
        dir_next   = DIR_STOP;
        level_next = '0;
        if (pos_ext > goal)
        begin
            if ((pos_ext - goal) > band)
            begin
                dir_next   = DIR_FWD;
                level_next = speed_reg;
            end
        end
        else if ((goal - pos_ext) > band)
        begin
            dir_next   = DIR_REV;
            level_next = speed_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: result register.
    // ------------------------------------------------------------------
    logic               out_valid_reg;
    dir_t               dir_reg;
    logic [SPEED_W-1:0] level_reg;
    logic [POS_W-1:0]   pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            dir_reg   <= dir_next;
            level_reg <= level_next;
            pos_reg   <= avg_sum;
        end
    end

    assign out_valid         = out_valid_reg;
    assign direction         = dir_reg;
    assign drive_level       = level_reg;
    assign filtered_position = pos_reg;

    `ASSERT_CLK(a_stop_idle, clk, rst_n, !(out_valid && direction == DIR_STOP) || drive_level == '0,
        "drive level nonzero while stopped")
    `ASSERT_CLK(a_move_speed, clk, rst_n,
        !(out_valid && direction != DIR_STOP) || drive_level == speed_reg,
        "drive level differs from configured speed while moving")
    `ASSERT_CLK(a_back_press, clk, rst_n, !(out_valid && out_stall) || in_stall,
        "input accepted while result is held")

endmodule
